[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the controller RTL
// Clocked on clock and silenced while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition that holds at every clock edge
`define CPD_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication
`define CPD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define CPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CPD_ASSERT(lbl, expr, msg)
`define CPD_ASSERT_IMPL(lbl, ante, cons, msg)
`define CPD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/cpd_pkg.sv]
// ----------------------------------------------------------------------------
// cpd_pkg
// Widths, register map, configuration type and the microcode program of the
// cascaded PI duty controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

   // Field widths
   localparam int SIG_W     = 16;           // Q8.8 signals
   localparam int GAIN_W    = 16;           // Q3.13 gains
   localparam int LIMIT_W   = 15;           // unsigned clamps
   localparam int DUTY_W    = 20;
   localparam int ERR_W     = SIG_W + 1;    // exact difference of two signals
   localparam int PREV_I_W  = ERR_W + 1;    // stored current error
   localparam int DIFF_W    = PREV_I_W + 1; // error minus previous error
   localparam int MUL_A_W   = GAIN_W + 1;   // gain as a signed operand
   localparam int PROD_W    = MUL_A_W + DIFF_W;
   localparam int ACC_W     = PROD_W + 1;

   localparam int GAIN_FRAC_BITS  = 13;
   localparam int DUTY_MULTIPLIER = 30;
   localparam int INC_W           = ACC_W - GAIN_FRAC_BITS;
   localparam int SUM_W           = INC_W + 1;
   localparam int ROUND_HALF      = 1 << (GAIN_FRAC_BITS - 1);

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VOLTAGE_REFERENCE  = 3'd0,
      REG_VOLTAGE_PROP_GAIN  = 3'd1,
      REG_VOLTAGE_INTEG_GAIN = 3'd2,
      REG_SETPOINT_LIMIT     = 3'd3,
      REG_CURRENT_PROP_GAIN  = 3'd4,
      REG_CURRENT_INTEG_GAIN = 3'd5,
      REG_DRIVE_MAX          = 3'd6
   } reg_idx_type;

   localparam logic signed [SIG_W-1:0] RST_VOLTAGE_REFERENCE  = 16'sd1280;
   localparam logic [GAIN_W-1:0]       RST_VOLTAGE_PROP_GAIN  = 16'd4009;
   localparam logic [GAIN_W-1:0]       RST_VOLTAGE_INTEG_GAIN = 16'd143;
   localparam logic [LIMIT_W-1:0]      RST_SETPOINT_LIMIT     = 15'd5120;
   localparam logic [GAIN_W-1:0]       RST_CURRENT_PROP_GAIN  = 16'd25058;
   localparam logic [GAIN_W-1:0]       RST_CURRENT_INTEG_GAIN = 16'd1844;
   localparam logic [LIMIT_W-1:0]      RST_DRIVE_MAX          = 15'd2560;

   typedef struct packed {
      logic signed [SIG_W-1:0] voltage_reference;
      logic [GAIN_W-1:0]       voltage_prop_gain;
      logic [GAIN_W-1:0]       voltage_integ_gain;
      logic [LIMIT_W-1:0]      setpoint_limit;
      logic [GAIN_W-1:0]       current_prop_gain;
      logic [GAIN_W-1:0]       current_integ_gain;
      logic [LIMIT_W-1:0]      drive_max;
   } cfg_type;

   // Microcode
   localparam int STEP_W = 4;

   typedef enum logic [2:0] {
      OP_EVAL,      // error and error difference of the selected loop
      OP_MUL_P,     // kp * difference
      OP_MUL_I,     // park kp product with rounding, ki * error
      OP_SUM,       // add both products
      OP_UPDATE,    // shift, add to loop state, clamp, store error
      OP_DUTY_MUL,  // multiplier times switch voltage
      OP_DUTY_SAT,  // saturate into held duty
      OP_EMIT       // hand held duty to the output register
   } dp_op_type;

   typedef enum logic {
      LOOP_VOLTAGE,
      LOOP_CURRENT
   } loop_type;

   typedef enum logic {
      JC_NONE,
      JC_NO_STROBE
   } jump_cond_type;

   typedef struct packed {
      dp_op_type           op;
      loop_type            loop;
      jump_cond_type       jc;
      logic [STEP_W-1:0]   target;
      logic                last;
   } ctl_word_type;

   // Control handed from the sequencer to the datapath
   typedef struct packed {
      logic      run;
      dp_op_type op;
      loop_type  loop;
   } dp_ctl_type;

   localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
   localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd12;
   localparam logic [STEP_W-1:0] STEP_LAST  = STEP_EMIT;

   function automatic ctl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      w = '{op: OP_EMIT, loop: LOOP_VOLTAGE, jc: JC_NONE, target: STEP_FIRST, last: 1'b1};
      unique case (step)
         4'd0:  w = '{op: OP_EVAL,     loop: LOOP_VOLTAGE, jc: JC_NO_STROBE,
                     target: STEP_EMIT, last: 1'b0};
         4'd1:  w = '{op: OP_MUL_P,    loop: LOOP_VOLTAGE, jc: JC_NONE,
                     target: STEP_FIRST, last: 1'b0};
         4'd2:  w = '{op: OP_MUL_I,    loop: LOOP_VOLTAGE, jc: JC_NONE,
                     target: STEP_FIRST, last: 1'b0};
         4'd3:  w = '{op: OP_SUM,      loop: LOOP_VOLTAGE, jc: JC_NONE,
                     target: STEP_FIRST, last: 1'b0};
         4'd4:  w = '{op: OP_UPDATE,   loop: LOOP_VOLTAGE, jc: JC_NONE,
                     target: STEP_FIRST, last: 1'b0};
         4'd5:  w = '{op: OP_EVAL,     loop: LOOP_CURRENT, jc: JC_NONE,
                     target: STEP_FIRST, last: 1'b0};
         4'd6:  w = '{op: OP_MUL_P,    loop: LOOP_CURRENT, jc: JC_NONE,
                     target: STEP_FIRST, last: 1'b0};
         4'd7:  w = '{op: OP_MUL_I,    loop: LOOP_CURRENT, jc: JC_NONE,
                     target: STEP_FIRST, last: 1'b0};
         4'd8:  w = '{op: OP_SUM,      loop: LOOP_CURRENT, jc: JC_NONE,
                     target: STEP_FIRST, last: 1'b0};
         4'd9:  w = '{op: OP_UPDATE,   loop: LOOP_CURRENT, jc: JC_NONE,
                     target: STEP_FIRST, last: 1'b0};
         4'd10: w = '{op: OP_DUTY_MUL, loop: LOOP_CURRENT, jc: JC_NONE,
                     target: STEP_FIRST, last: 1'b0};
         4'd11: w = '{op: OP_DUTY_SAT, loop: LOOP_CURRENT, jc: JC_NONE,
                     target: STEP_FIRST, last: 1'b0};
         default: w = '{op: OP_EMIT,   loop: LOOP_VOLTAGE, jc: JC_NONE,
                     target: STEP_FIRST, last: 1'b1};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[rtl/cpd_csr.sv]
// ----------------------------------------------------------------------------
// cpd_csr
// Configuration register bank behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [cpd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [cpd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [cpd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output cpd_pkg::cfg_type                    cfg
);
   import cpd_pkg::*;

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_en;
   logic [CSR_IDX_W-1:0]   idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_VOLTAGE_REFERENCE:  cfg_in.voltage_reference  = $signed(csr_pwdata[SIG_W-1:0]);
            REG_VOLTAGE_PROP_GAIN:  cfg_in.voltage_prop_gain  = csr_pwdata[GAIN_W-1:0];
            REG_VOLTAGE_INTEG_GAIN: cfg_in.voltage_integ_gain = csr_pwdata[GAIN_W-1:0];
            REG_SETPOINT_LIMIT:     cfg_in.setpoint_limit     = csr_pwdata[LIMIT_W-1:0];
            REG_CURRENT_PROP_GAIN:  cfg_in.current_prop_gain  = csr_pwdata[GAIN_W-1:0];
            REG_CURRENT_INTEG_GAIN: cfg_in.current_integ_gain = csr_pwdata[GAIN_W-1:0];
            REG_DRIVE_MAX:          cfg_in.drive_max          = csr_pwdata[LIMIT_W-1:0];
            default: ;  // unmapped: drop the write
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_VOLTAGE_REFERENCE:
            csr_prdata = {{(CSR_DATA_W-SIG_W){1'b0}}, cfg_ff.voltage_reference};
         REG_VOLTAGE_PROP_GAIN:
            csr_prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.voltage_prop_gain};
         REG_VOLTAGE_INTEG_GAIN:
            csr_prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.voltage_integ_gain};
         REG_SETPOINT_LIMIT:
            csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, cfg_ff.setpoint_limit};
         REG_CURRENT_PROP_GAIN:
            csr_prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.current_prop_gain};
         REG_CURRENT_INTEG_GAIN:
            csr_prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.current_integ_gain};
         REG_DRIVE_MAX:
            csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, cfg_ff.drive_max};
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.voltage_reference  <= RST_VOLTAGE_REFERENCE;
         cfg_ff.voltage_prop_gain  <= RST_VOLTAGE_PROP_GAIN;
         cfg_ff.voltage_integ_gain <= RST_VOLTAGE_INTEG_GAIN;
         cfg_ff.setpoint_limit     <= RST_SETPOINT_LIMIT;
         cfg_ff.current_prop_gain  <= RST_CURRENT_PROP_GAIN;
         cfg_ff.current_integ_gain <= RST_CURRENT_INTEG_GAIN;
         cfg_ff.drive_max          <= RST_DRIVE_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/cpd_sequencer.sv]
// ----------------------------------------------------------------------------
// cpd_sequencer
// Step counter over the microcode table, with the strobe jump and the
// hand-off of the finished beat to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cpd_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_stall,
   input  wire logic                strobe,
   input  wire logic                out_free,
   output logic                     start,
   output logic                     emit,
   output cpd_pkg::dp_ctl_type      ctl
);
   import cpd_pkg::*;

   logic                busy_ff;
   logic                busy_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   ctl_word_type        cw;

   assign cw       = ucode_rom(step_ff);
   // hold off input beats while reset is high as well as while busy
   assign in_stall = busy_ff | reset;
   assign start    = in_valid & ~in_stall;
   assign emit     = busy_ff & cw.last & out_free;

   assign ctl.run  = busy_ff;
   assign ctl.op   = cw.op;
   assign ctl.loop = cw.loop;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      priority if (!busy_ff) begin
         if (in_valid) begin
            busy_in = 1'b1;
            step_in = STEP_FIRST;
         end
      end else if (cw.last) begin
         if (out_free) begin
            busy_in = 1'b0;
         end
      end else if (cw.jc == JC_NO_STROBE && !strobe) begin
         step_in = cw.target;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_FIRST;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   `CPD_ASSERT_IMPL(a_step_in_program, busy_ff, step_ff <= STEP_LAST, "step beyond program")
   `CPD_ASSERT_NEXT(a_start_at_top, start, busy_ff && step_ff == STEP_FIRST, "bad program start")
   `CPD_ASSERT_IMPL(a_emit_on_last, emit, busy_ff && cw.op == OP_EMIT, "emit off last step")
   `CPD_ASSERT_NEXT(a_emit_frees, emit, !busy_ff, "sequencer busy after emit")

endmodule

`default_nettype wire

[rtl/cpd_datapath.sv]
// ----------------------------------------------------------------------------
// cpd_datapath
// Shared multiplier, accumulator and loop state of both PI loops, driven by
// one microcode control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          in_update_strobe,
   input  wire logic signed [cpd_pkg::SIG_W-1:0] in_v_measured,
   input  wire logic signed [cpd_pkg::SIG_W-1:0] in_i_measured,
   input  cpd_pkg::cfg_type                   cfg,
   input  cpd_pkg::dp_ctl_type                ctl,
   output logic                               strobe,
   output logic             [cpd_pkg::DUTY_W-1:0] held_duty
);
   import cpd_pkg::*;

   // Latched sample
   logic                       strobe_ff;
   logic signed [SIG_W-1:0]    v_ff;
   logic signed [SIG_W-1:0]    i_ff;

   // Loop state
   logic signed [ERR_W-1:0]    prev_v_err_ff;
   logic signed [SIG_W-1:0]    setpoint_ff;
   logic signed [PREV_I_W-1:0] prev_i_err_ff;
   logic signed [SIG_W-1:0]    switch_v_ff;
   logic        [DUTY_W-1:0]   held_duty_ff;

   // Working registers
   logic signed [ERR_W-1:0]    err_ff;
   logic signed [DIFF_W-1:0]   diff_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;

   logic signed [ERR_W-1:0]    err_c;
   logic signed [DIFF_W-1:0]   prev_c;
   logic signed [DIFF_W-1:0]   diff_c;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [DIFF_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [INC_W-1:0]    inc_c;
   logic signed [SUM_W-1:0]    sum_c;
   logic signed [SUM_W-1:0]    hi_c;
   logic signed [SUM_W-1:0]    lo_c;
   logic signed [SUM_W-1:0]    clamp_c;
   logic        [DUTY_W-1:0]   sat_c;

   assign strobe    = strobe_ff;
   assign held_duty = held_duty_ff;

   // Error of the selected loop and its step against the stored error
   always_comb begin
      unique case (ctl.loop)
         LOOP_VOLTAGE: begin
            err_c  = {cfg.voltage_reference[SIG_W-1], cfg.voltage_reference}
                   - {v_ff[SIG_W-1], v_ff};
            prev_c = {{(DIFF_W-ERR_W){prev_v_err_ff[ERR_W-1]}}, prev_v_err_ff};
         end
         LOOP_CURRENT: begin
            err_c  = {setpoint_ff[SIG_W-1], setpoint_ff} - {i_ff[SIG_W-1], i_ff};
            prev_c = {{(DIFF_W-PREV_I_W){prev_i_err_ff[PREV_I_W-1]}}, prev_i_err_ff};
         end
         default: begin
            err_c  = '0;
            prev_c = '0;
         end
      endcase
      diff_c = {{(DIFF_W-ERR_W){err_c[ERR_W-1]}}, err_c} - prev_c;
   end

   // Operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctl.op)
         OP_MUL_P: begin
            mul_a = (ctl.loop == LOOP_VOLTAGE) ? $signed({1'b0, cfg.voltage_prop_gain})
                                               : $signed({1'b0, cfg.current_prop_gain});
            mul_b = diff_ff;
         end
         OP_MUL_I: begin
            mul_a = (ctl.loop == LOOP_VOLTAGE) ? $signed({1'b0, cfg.voltage_integ_gain})
                                               : $signed({1'b0, cfg.current_integ_gain});
            mul_b = {{(DIFF_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         OP_DUTY_MUL: begin
            mul_a = MUL_A_W'(DUTY_MULTIPLIER);
            mul_b = {{(DIFF_W-SIG_W){switch_v_ff[SIG_W-1]}}, switch_v_ff};
         end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   // Floor shift of the rounded sum, add to loop state, clamp
   always_comb begin
      inc_c = acc_ff[ACC_W-1:GAIN_FRAC_BITS];
      hi_c  = '0;
      lo_c  = '0;
      sum_c = '0;
      unique case (ctl.loop)
         LOOP_VOLTAGE: begin
            sum_c = {{(SUM_W-SIG_W){setpoint_ff[SIG_W-1]}}, setpoint_ff}
                  + {inc_c[INC_W-1], inc_c};
            hi_c  = {{(SUM_W-LIMIT_W){1'b0}}, cfg.setpoint_limit};
            lo_c  = -hi_c;
         end
         LOOP_CURRENT: begin
            sum_c = {{(SUM_W-SIG_W){switch_v_ff[SIG_W-1]}}, switch_v_ff}
                  + {inc_c[INC_W-1], inc_c};
            hi_c  = {{(SUM_W-LIMIT_W){1'b0}}, cfg.drive_max};
            lo_c  = '0;
         end
         default: ;
      endcase
      priority if (sum_c > hi_c) begin
         clamp_c = hi_c;
      end else if (sum_c < lo_c) begin
         clamp_c = lo_c;
      end else begin
         clamp_c = sum_c;
      end
   end

   // Switch voltage is never negative, so only the top bits decide
   assign sat_c = (|prod_ff[PROD_W-1:DUTY_W]) ? {DUTY_W{1'b1}} : prod_ff[DUTY_W-1:0];

   // Sample latch and working registers
   always_ff @(posedge clock) begin
      if (start) begin
         strobe_ff <= in_update_strobe;
         v_ff      <= in_v_measured;
         i_ff      <= in_i_measured;
      end
      if (ctl.run) begin
         unique case (ctl.op)
            OP_EVAL: begin
               err_ff  <= err_c;
               diff_ff <= diff_c;
            end
            OP_MUL_P, OP_DUTY_MUL: begin
               prod_ff <= mul_p;
            end
            OP_MUL_I: begin
               acc_ff  <= {prod_ff[PROD_W-1], prod_ff} + ACC_W'(ROUND_HALF);
               prod_ff <= mul_p;
            end
            OP_SUM: begin
               acc_ff  <= acc_ff + {prod_ff[PROD_W-1], prod_ff};
            end
            default: ;
         endcase
      end
   end

   // Loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_v_err_ff <= '0;
         setpoint_ff   <= '0;
         prev_i_err_ff <= '0;
         switch_v_ff   <= '0;
         held_duty_ff  <= '0;
      end else if (ctl.run) begin
         unique case (ctl.op)
            OP_UPDATE: begin
               if (ctl.loop == LOOP_VOLTAGE) begin
                  setpoint_ff   <= clamp_c[SIG_W-1:0];
                  prev_v_err_ff <= err_ff;
               end else begin
                  switch_v_ff   <= clamp_c[SIG_W-1:0];
                  prev_i_err_ff <= {err_ff[ERR_W-1], err_ff};
               end
            end
            OP_DUTY_SAT: begin
               held_duty_ff <= sat_c;
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/cascaded_pi_duty_controller_core.sv]
// ----------------------------------------------------------------------------
// cascaded_pi_duty_controller_core
// Cascaded voltage/current PI controller producing a converter duty command.
// ----------------------------------------------------------------------------
// Each input beat carries an update strobe and the measured voltage and
// current (signed Q8.8) and yields exactly one output beat, duty_value. With
// the strobe set, the outer voltage loop adds a velocity-form PI increment
// (kp on the error step, ki on the error, gains unsigned Q3.13, rounded half
// up) to the current setpoint and clamps it to plus or minus setpoint_limit;
// the inner current loop does the same to the switch voltage, clamped to
// zero..drive_max, and the duty value becomes thirty times that voltage.
// Without the strobe the previous duty value is repeated and no state moves.
// Sequencing: a strobed beat walks the 13-step microcode program that runs
// both loops and the duty product through one shared 17 x 19 bit multiplier,
// at most one product per step; a held beat jumps from the first step to the
// emit step. A new beat is taken only once the program is done, but the
// output register lets it be taken while the last result waits on rsp_stall.
// Configuration registers sit at byte addresses 4*i on the csr_ port, are
// written with psel, penable and pwrite high, and must only change while the
// block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_pi_duty_controller_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input beats
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_update_strobe,
   input  wire logic signed [cpd_pkg::SIG_W-1:0]  req_v_measured,
   input  wire logic signed [cpd_pkg::SIG_W-1:0]  req_i_measured,
   // result beats
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic             [cpd_pkg::DUTY_W-1:0] rsp_duty_value,
   // configuration
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic        [cpd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic        [cpd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic             [cpd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                   csr_pready
);
   import cpd_pkg::*;

   cfg_type                cfg;
   dp_ctl_type             ctl;
   logic                   start;
   logic                   emit;
   logic                   strobe;
   logic                   out_free;
   logic [DUTY_W-1:0]      held_duty;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [DUTY_W-1:0]      rsp_duty_ff;

   // Register bank
   cpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Microcode sequencer: accepts a beat when idle, walks the program,
   // jumps straight to the emit step when the strobe is clear
   cpd_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .strobe   (strobe),
      .out_free (out_free),
      .start    (start),
      .emit     (emit),
      .ctl      (ctl)
   );

   // Shared-multiplier datapath holding both loops' state
   cpd_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .in_update_strobe (req_update_strobe),
      .in_v_measured    (req_v_measured),
      .in_i_measured    (req_i_measured),
      .cfg              (cfg),
      .ctl              (ctl),
      .strobe           (strobe),
      .held_duty        (held_duty)
   );

   // Output register: the slot is free when empty or being drained this cycle
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (emit) begin
         rsp_valid_in = 1'b1;      // load the new beat
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;      // drop the beat once taken
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_duty_ff <= held_duty;  // hold until taken
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duty_value = rsp_duty_ff;

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// Cascaded PI duty controller testbench
// Drives sample beats through the controller and checks every duty beat
// against a bit-true model of both PI loops. The stimulus runs over reset,
// extreme and random register settings, with random gaps on the input and
// random back-pressure on the output.
// ----------------------------------------------------------------------------

class duty_scoreboard;
   // register copies
   logic signed [cpd_pkg::SIG_W-1:0]    v_ref;
   logic        [cpd_pkg::GAIN_W-1:0]   v_kp, v_ki, i_kp, i_ki;
   logic        [cpd_pkg::LIMIT_W-1:0]  sp_limit, sw_max;
   // loop state
   logic signed [cpd_pkg::ERR_W-1:0]    v_err_last;
   logic signed [cpd_pkg::SIG_W-1:0]    setpoint;
   logic signed [cpd_pkg::PREV_I_W-1:0] i_err_last;
   logic signed [cpd_pkg::SIG_W-1:0]    sw_volt;
   logic        [cpd_pkg::DUTY_W-1:0]   held_duty;
   // duty values still owed by the block
   logic        [cpd_pkg::DUTY_W-1:0]   duty_q[$];
   int fails, samples, strobed, beats, writes;

   function new();
      v_ref      = 16'sd1280;
      v_kp       = 16'd4009;
      v_ki       = 16'd143;
      sp_limit   = 15'd5120;
      i_kp       = 16'd25058;
      i_ki       = 16'd1844;
      sw_max     = 15'd2560;
      v_err_last = '0;
      setpoint   = '0;
      i_err_last = '0;
      sw_volt    = '0;
      held_duty  = '0;
   endfunction

   function void write_reg(int idx, logic [cpd_pkg::CSR_DATA_W-1:0] data);
      writes++;
      case (idx)
         cpd_pkg::REG_VOLTAGE_REFERENCE:  v_ref    = data[cpd_pkg::SIG_W-1:0];
         cpd_pkg::REG_VOLTAGE_PROP_GAIN:  v_kp     = data[cpd_pkg::GAIN_W-1:0];
         cpd_pkg::REG_VOLTAGE_INTEG_GAIN: v_ki     = data[cpd_pkg::GAIN_W-1:0];
         cpd_pkg::REG_SETPOINT_LIMIT:     sp_limit = data[cpd_pkg::LIMIT_W-1:0];
         cpd_pkg::REG_CURRENT_PROP_GAIN:  i_kp     = data[cpd_pkg::GAIN_W-1:0];
         cpd_pkg::REG_CURRENT_INTEG_GAIN: i_ki     = data[cpd_pkg::GAIN_W-1:0];
         cpd_pkg::REG_DRIVE_MAX:          sw_max   = data[cpd_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // velocity-form increment, rounded half up by a floor shift
   function longint pi_step(longint kp, longint ki, longint err, longint last);
      longint acc;
      acc = kp * (err - last) + ki * err + (longint'(1) <<< (cpd_pkg::GAIN_FRAC_BITS - 1));
      return acc >>> cpd_pkg::GAIN_FRAC_BITS;
   endfunction

   function longint clip(longint x, longint lo, longint hi);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   function void note_sample(logic strobe, logic signed [cpd_pkg::SIG_W-1:0] v,
                             logic signed [cpd_pkg::SIG_W-1:0] i);
      longint v_err, i_err, sp, sv, duty, duty_ceil;
      samples++;
      if (strobe) begin
         strobed++;
         duty_ceil = (longint'(1) <<< cpd_pkg::DUTY_W) - 1;
         v_err = longint'(v_ref) - longint'(v);
         sp = clip(longint'(setpoint) + pi_step(v_kp, v_ki, v_err, longint'(v_err_last)),
                   -longint'(sp_limit), longint'(sp_limit));
         setpoint   = sp[cpd_pkg::SIG_W-1:0];
         v_err_last = v_err[cpd_pkg::ERR_W-1:0];
         i_err = sp - longint'(i);
         sv = clip(longint'(sw_volt) + pi_step(i_kp, i_ki, i_err, longint'(i_err_last)),
                   0, longint'(sw_max));
         sw_volt    = sv[cpd_pkg::SIG_W-1:0];
         i_err_last = i_err[cpd_pkg::PREV_I_W-1:0];
         duty = sv * cpd_pkg::DUTY_MULTIPLIER;
         if (duty > duty_ceil) duty = duty_ceil;
         held_duty = duty[cpd_pkg::DUTY_W-1:0];
      end
      duty_q.push_back(held_duty);
   endfunction

   function void check_duty(logic [cpd_pkg::DUTY_W-1:0] got);
      logic [cpd_pkg::DUTY_W-1:0] want;
      beats++;
      if (duty_q.size() == 0) begin
         fails++;
         $display("%0t: duty beat with none expected: got %0d", $time, got);
      end else begin
         want = duty_q.pop_front();
         if (got !== want) begin
            fails++;
            $display("%0t: duty_value mismatch: expected %0d, got %0d", $time, want, got);
         end
      end
   endfunction
endclass

module tb;
   import cpd_pkg::*;

   // index past the end of the register map; writes to it must be dropped
   localparam int SPARE_REG_IDX = 7;
   localparam int SEGMENTS      = 8;
   localparam int SEG_SAMPLES   = 235;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int DRAIN_CYCLES  = 40;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_update_strobe;
   logic signed [SIG_W-1:0] req_v_measured;
   logic signed [SIG_W-1:0] req_i_measured;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [DUTY_W-1:0]       rsp_duty_value;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   duty_scoreboard sb;
   int send_idle_pct;
   int stall_pct;
   int idle_cycles;

   cascaded_pi_duty_controller_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_update_strobe (req_update_strobe),
      .req_v_measured    (req_v_measured),
      .req_i_measured    (req_i_measured),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_duty_value    (rsp_duty_value),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   // Back-pressure: redraw the stall at every falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Monitor both channels at the rising edge: check a finished duty beat
   // first, then note the sample beat taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_duty(rsp_duty_value);
         if (req_valid === 1'b1 && req_stall === 1'b0)
            sb.note_sample(req_update_strobe, req_v_measured, req_i_measured);
      end
   end

   // Watchdog: count edges on which no beat moves and no register access runs
   always @(posedge clock) begin
      if (reset || csr_psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_MAX);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Offer one sample beat; entered and left at a falling edge. Insert random
   // gaps first, then hold the beat until the block takes it.
   task automatic send_sample(input logic strobe, input logic signed [SIG_W-1:0] v,
                              input logic signed [SIG_W-1:0] i);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_update_strobe <= strobe;
      req_v_measured    <= v;
      req_i_measured    <= i;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed duty beat has come back
   task automatic drain;
      req_valid <= 1'b0;
      while (sb.duty_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // One register write: setup cycle, access cycle, then an idle cycle so
   // that back-to-back writes never lower and raise psel in one step
   task automatic csr_write(input int idx, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Write a value with random junk above the register width
   task automatic csr_write_field(input int idx, input int val, input int width);
      logic [CSR_DATA_W-1:0] mask;
      mask = (32'd1 << width) - 1;
      csr_write(idx, ($urandom & ~mask) | (32'(val) & mask));
   endtask

   task automatic apply_config(input int vref, input int vkp, input int vki, input int splim,
                               input int ikp, input int iki, input int dmax);
      csr_write_field(REG_VOLTAGE_REFERENCE,  vref,  SIG_W);
      csr_write_field(REG_VOLTAGE_PROP_GAIN,  vkp,   GAIN_W);
      csr_write_field(REG_VOLTAGE_INTEG_GAIN, vki,   GAIN_W);
      csr_write_field(REG_SETPOINT_LIMIT,     splim, LIMIT_W);
      csr_write_field(REG_CURRENT_PROP_GAIN,  ikp,   GAIN_W);
      csr_write_field(REG_CURRENT_INTEG_GAIN, iki,   GAIN_W);
      csr_write_field(REG_DRIVE_MAX,          dmax,  LIMIT_W);
   endtask

   task automatic apply_reset_config;
      apply_config(1280, 4009, 143, 5120, 25058, 1844, 2560);
   endtask

   // Lean towards the nominal setting so the loops do real work; keep the
   // ends of each range and plain random values in the mix
   function automatic int pick(input int lo, input int hi, input int typical);
      case ($urandom_range(5))
         0:       return lo;
         1:       return hi;
         2, 3:    return typical;
         default: return lo + int'($urandom_range(hi - lo));
      endcase
   endfunction

   // Measurement around a working point, with full-range noise and extremes
   function automatic logic signed [SIG_W-1:0] draw_signal(input logic signed [SIG_W-1:0] centre);
      logic [SIG_W-1:0] raw;
      longint x;
      raw = SIG_W'($urandom);
      case ($urandom_range(9))
         0, 1:    return raw;
         2:       return raw[0] ? 16'sh7fff : 16'sh8000;
         default: begin
            x = longint'(centre) + longint'($urandom_range(512)) - 256;
            if (x > 32767) x = 32767;
            if (x < -32768) x = -32768;
            return x[SIG_W-1:0];
         end
      endcase
   endfunction

   initial begin
      int seg;
      int n;
      logic strobe;
      logic signed [SIG_W-1:0] v;
      logic signed [SIG_W-1:0] i;

      sb = new();
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_update_strobe = 1'b0;
      req_v_measured    = '0;
      req_i_measured    = '0;
      rsp_stall         = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      idle_cycles       = 0;

      // Hold reset at the start, release it at a falling edge
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset settings; a hold before any update, no error, extremes
      send_sample(1'b0, 16'sd0, 16'sd0);
      send_sample(1'b1, 16'sd1280, 16'sd0);
      send_sample(1'b1, 16'sd0, 16'sd0);
      send_sample(1'b1, 16'sd0, 16'sd0);
      send_sample(1'b0, -16'sd1, -16'sd1);
      send_sample(1'b1, 16'sh7fff, 16'sh8000);
      send_sample(1'b1, 16'sh8000, 16'sh7fff);
      send_sample(1'b1, 16'sh8000, 16'sh8000);
      drain;

      // Everything at its maximum: drive the switch voltage to the top
      apply_config(32767, 65535, 65535, 32767, 65535, 65535, 32767);
      send_sample(1'b1, 16'sh8000, 16'sh8000);
      send_sample(1'b1, 16'sh8000, 16'sh8000);
      send_sample(1'b0, 16'sd0, 16'sd0);
      drain;

      // Lowest reference: pull both loops to their lower clamps
      csr_write_field(REG_VOLTAGE_REFERENCE, -32768, SIG_W);
      send_sample(1'b1, 16'sh7fff, 16'sh7fff);
      send_sample(1'b1, 16'sh7fff, 16'sh8000);
      drain;

      // Zero setpoint limit pins the current setpoint at zero
      apply_config(1280, 4009, 143, 0, 25058, 1844, 2560);
      send_sample(1'b1, 16'sd0, 16'sd0);
      send_sample(1'b1, 16'sh8000, 16'sd0);
      send_sample(1'b1, 16'sd0, 16'sh8000);
      drain;

      // Zero drive maximum forces the duty to zero
      apply_config(1280, 4009, 143, 5120, 25058, 1844, 0);
      send_sample(1'b1, 16'sh8000, 16'sh8000);
      send_sample(1'b1, 16'sd0, 16'sd0);
      drain;

      // Zero gains freeze both loops
      apply_config(1280, 0, 0, 5120, 0, 0, 2560);
      send_sample(1'b1, 16'sd0, 16'sd0);
      send_sample(1'b1, 16'sh8000, 16'sh7fff);
      drain;

      // A write past the register map must change nothing
      csr_write(SPARE_REG_IDX, $urandom);
      send_sample(1'b1, 16'sd0, 16'sd0);
      drain;

      apply_reset_config;
      send_sample(1'b1, 16'sd1280, 16'sd0);
      send_sample(1'b1, 16'sd1000, 16'sd200);
      send_sample(1'b0, 16'sd0, 16'sd0);
      drain;

      // Random segments: fresh settings each time, cycling the idle profile
      for (seg = 0; seg < SEGMENTS; seg++) begin
         apply_config(pick(-32768, 32767, 1280), pick(0, 65535, 4009), pick(0, 65535, 143),
                      pick(0, 32767, 5120), pick(0, 65535, 25058), pick(0, 65535, 1844),
                      pick(0, 32767, 2560));
         case (seg % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 9; stall_pct = 9; end
         endcase
         for (n = 0; n < SEG_SAMPLES; n++) begin
            strobe = ($urandom_range(9) < 8);
            v = draw_signal(sb.v_ref);
            i = draw_signal(sb.setpoint);
            send_sample(strobe, v, i);
         end
         drain;
      end

      // Let any stray beat surface before judging
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.duty_q.size() != 0) begin
         sb.fails++;
         $display("%0t: %0d duty beats never arrived", $time, sb.duty_q.size());
      end

      $display("tb: %0d sample beats (%0d strobed), %0d duty beats checked",
               sb.samples, sb.strobed, sb.beats);
      $display("tb: %0d register writes over %0d random settings, %0d mismatches",
               sb.writes, SEGMENTS, sb.fails);
      if (sb.fails == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
